// ===== hdl/v3a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_pkg: shared types, codes and helpers for the 3D vector ALU
// Operation codes, pipeline depths, saturation and rounding helpers.
// ----------------------------------------------------------------------------
package v3a_pkg;

    // operation codes
    localparam logic [1:0] OP_DOT   = 2'd0;
    localparam logic [1:0] OP_CROSS = 2'd1;
    localparam logic [1:0] OP_SUB   = 2'd2;
    localparam logic [1:0] OP_NORM  = 2'd3;

    // square root: one result bit per stage
    localparam int SQRT_N = 32;
    // quotient bits of a unit component (result never above 1.0)
    localparam int QW     = 17;
    // divider: one setup stage plus one stage per quotient bit
    localparam int DIV_N  = QW + 1;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic signed [63:0] prod;   // first product, one stage earlier
        logic signed [31:0] res;    // cross or subtract result
        logic               ovf;
        logic               neg;    // sign of the u component
        logic [31:0]        mag;    // magnitude of the u component
    } t_lane_out;

    // per-item data riding along the square root and divider
    typedef struct packed {
        logic [1:0]        op;
        logic [2:0][31:0]  res;
        logic [31:0]       scalar;
        logic              ovf;
        logic [2:0]        neg;
        logic [2:0][31:0]  mag;
        logic              zlen;
    } t_side;

    // clamp to signed 32 bits
    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat s;
        s.ovf = 1'b1;
        if (v > 66'sd2147483647) begin
            s.val = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            s.val = 32'sh80000000;
        end else begin
            s.val = v[31:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

    // Q32.32 to Q16.16, nearest with ties toward +inf
    function automatic logic signed [65:0] round_q16(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd32768;
        return t >>> 16;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/v3a_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_if: item channels of the 3D vector ALU
// Valid/ready channels for the operand item and the result item.
// ----------------------------------------------------------------------------
interface v3a_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] u_x;
    logic signed [31:0] u_y;
    logic signed [31:0] u_z;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;

    modport source(output valid, op, u_x, u_y, u_z, v_x, v_y, v_z, input ready);
    modport sink(input valid, op, u_x, u_y, u_z, v_x, v_y, v_z, output ready);
endinterface

interface v3a_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar;
    logic               overflow;
    logic               zero_length;

    modport source(output valid, r_x, r_y, r_z, scalar, overflow, zero_length,
                   input ready);
    modport sink(input valid, r_x, r_y, r_z, scalar, overflow, zero_length,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/v3a_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_lane: one component lane of the vector ALU
// Stage 1 multiplies and subtracts, stage 2 rounds the cross term.
// ----------------------------------------------------------------------------
module v3a_lane (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire [1:0]           i_op,
    input  wire signed [31:0]   i_u_self,
    input  wire signed [31:0]   i_v_self,
    input  wire signed [31:0]   i_u_k1,
    input  wire signed [31:0]   i_v_k2,
    input  wire signed [31:0]   i_u_k2,
    input  wire signed [31:0]   i_v_k1,
    output v3a_pkg::t_lane_out  o_lane
);

    logic signed [31:0] ma, mb, mc, md;
    logic signed [63:0] p_a, p_b;
    logic signed [65:0] sub_d;
    logic signed [65:0] cr_d;
    v3a_pkg::t_sat      cr_s;

    logic signed [63:0] r_pa, r_pb;
    v3a_pkg::t_sat      r_sub;
    logic [1:0]         r_op;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic signed [31:0] r_res;
    logic               r_ovf;
    logic               r_neg2;
    logic [31:0]        r_mag2;

    logic signed [31:0] n_res;
    logic               n_ovf;

    // multiplier operands by operation
    always_comb begin
        ma = '0; mb = '0; mc = '0; md = '0;
        case (i_op)
            v3a_pkg::OP_DOT: begin
                ma = i_u_self; mb = i_v_self;
            end
            v3a_pkg::OP_CROSS: begin
                ma = i_u_k1; mb = i_v_k2; mc = i_u_k2; md = i_v_k1;
            end
            v3a_pkg::OP_NORM: begin
                ma = i_u_self; mb = i_u_self;
            end
            default: begin
                ma = '0;
            end
        endcase
    end

    assign p_a   = ma * mb;
    assign p_b   = mc * md;
    assign sub_d = 66'(i_u_self) - 66'(i_v_self);

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= p_a;
            r_pb  <= p_b;
            r_sub <= v3a_pkg::sat32(sub_d);
            r_op  <= i_op;
            r_neg <= i_u_self[31];
            r_mag <= i_u_self[31] ? 32'(-i_u_self) : i_u_self;
        end
    end

    // cross term: exact difference, then round and clamp
    assign cr_d = 66'(r_pa) - 66'(r_pb);
    assign cr_s = v3a_pkg::sat32(v3a_pkg::round_q16(cr_d));

    always_comb begin
        n_res = '0;
        n_ovf = 1'b0;
        case (r_op)
            v3a_pkg::OP_CROSS: begin
                n_res = cr_s.val; n_ovf = cr_s.ovf;
            end
            v3a_pkg::OP_SUB: begin
                n_res = r_sub.val; n_ovf = r_sub.ovf;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_ovf  <= n_ovf;
            r_neg2 <= r_neg;
            r_mag2 <= r_mag;
        end
    end

    assign o_lane.prod = r_pa;
    assign o_lane.res  = r_res;
    assign o_lane.ovf  = r_ovf;
    assign o_lane.neg  = r_neg2;
    assign o_lane.mag  = r_mag2;

endmodule
`default_nettype wire

// ===== hdl/v3a_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module v3a_sqrt (
    input  wire         i_clk,
    input  wire         i_en,
    input  wire [63:0]  i_s,
    output logic [31:0] o_len
);

    logic [63:0] r_s   [v3a_pkg::SQRT_N];
    logic [63:0] r_res [v3a_pkg::SQRT_N];
    logic [63:0] n_s   [v3a_pkg::SQRT_N];
    logic [63:0] n_res [v3a_pkg::SQRT_N];

    // one digit step per stage, trial bit fixed by stage position
    always_comb begin
        for (int k = 0; k < v3a_pkg::SQRT_N; k++) begin
            logic [63:0] s_in, res_in, bit_k, trial;
            s_in   = (k == 0) ? i_s : r_s[(k == 0) ? 0 : k - 1];
            res_in = (k == 0) ? 64'd0 : r_res[(k == 0) ? 0 : k - 1];
            bit_k  = 64'd1 << (62 - 2 * k);
            trial  = res_in + bit_k;
            if (s_in >= trial) begin
                n_s[k]   = s_in - trial;
                n_res[k] = (res_in >> 1) + bit_k;
            end else begin
                n_s[k]   = s_in;
                n_res[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < v3a_pkg::SQRT_N; k++) begin
                r_s[k]   <= n_s[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_len = r_res[v3a_pkg::SQRT_N-1][31:0];

endmodule
`default_nettype wire

// ===== hdl/v3a_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_div: pipelined unit-component divider
// round(mag * 2^16 / len), ties away from zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3a_div (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire [31:0]               i_mag,
    input  wire [31:0]               i_len,
    output logic [v3a_pkg::QW-1:0]   o_q
);

    logic [31:0]             r_rem [v3a_pkg::DIV_N];
    logic [v3a_pkg::QW-1:0]  r_nq  [v3a_pkg::DIV_N];
    logic [31:0]             r_len [v3a_pkg::DIV_N];
    logic [31:0]             n_rem [v3a_pkg::DIV_N];
    logic [v3a_pkg::QW-1:0]  n_nq  [v3a_pkg::DIV_N];
    logic [48:0]             num;

    // numerator with half the divisor added for rounding
    assign num = {1'b0, i_mag, 16'd0} + 49'(i_len >> 1);

    always_comb begin
        // setup: upper part is already below the divisor
        n_rem[0] = num[48:v3a_pkg::QW];
        n_nq[0]  = num[v3a_pkg::QW-1:0];
        // restoring steps; quotient bits shift in as numerator bits leave
        for (int k = 1; k < v3a_pkg::DIV_N; k++) begin
            logic [32:0] t;
            logic        qb;
            t  = {r_rem[k-1], r_nq[k-1][v3a_pkg::QW-1]};
            qb = (t >= {1'b0, r_len[k-1]});
            n_rem[k] = qb ? 32'(t - {1'b0, r_len[k-1]}) : t[31:0];
            n_nq[k]  = {r_nq[k-1][v3a_pkg::QW-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < v3a_pkg::DIV_N; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_len[k] <= (k == 0) ? i_len : r_len[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_q = r_nq[v3a_pkg::DIV_N-1];

endmodule
`default_nettype wire

// ===== hdl/vector3_alu_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_alu_core: 3D vector dot, cross, subtract and normalize unit
// Three component lanes, a merge stage, a square root and three dividers.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries op and the vectors u and v in signed Q16.16; o_out carries
//   r_x, r_y, r_z, scalar and the overflow and zero_length flags. Both are
//   valid/ready channels; an item moves when valid and ready are high.
//   Every operation runs through the same pipeline (2 lane stages, 32
//   square-root stages, 18 divider stages, 1 output register), and results
//   leave in order. Throughput is one item per cycle while no result waits
//   on a low ready; the length of the pipeline is set by the square root,
//   which resolves one bit of the length per stage.
//   Reset clears all valid bits; nothing else needs clearing.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline holds and i_in.ready drops in the same cycle; bubbles in the
//   pipeline are not squeezed out.
// ----------------------------------------------------------------------------
module vector3_alu_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    v3a_in_if.sink     i_in,
    v3a_out_if.source  o_out
);

    localparam int SIDE_N = v3a_pkg::SQRT_N + v3a_pkg::DIV_N;
    localparam int VLD_N  = SIDE_N + 3;

    logic                 en;
    logic [VLD_N-1:0]     r_vld;
    logic [VLD_N-1:0]     n_vld;

    logic signed [31:0]   u_c [3];
    logic signed [31:0]   v_c [3];
    v3a_pkg::t_lane_out   lane [3];

    logic [1:0]           r_op1;
    logic [1:0]           r_op2;
    logic signed [65:0]   dot_sum;
    v3a_pkg::t_sat        dot_s;
    logic [63:0]          sq_sum;
    logic [31:0]          r_s2_scalar;
    logic                 r_s2_ovf;
    logic [63:0]          r_s2_sq;

    v3a_pkg::t_side       n_side0;
    v3a_pkg::t_side       n_side_sq;
    v3a_pkg::t_side       r_side [SIDE_N];
    logic [31:0]          len;
    logic [v3a_pkg::QW-1:0] q [3];

    logic signed [31:0]   r_rx, r_ry, r_rz, r_sc;
    logic                 r_ovf, r_zlen;
    logic signed [31:0]   n_r [3];
    logic signed [31:0]   n_sc;

    // global advance: stall only while a result waits
    assign en         = !r_vld[VLD_N-1] || o_out.ready;
    assign i_in.ready = en;

    assign n_vld = {r_vld[VLD_N-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    assign u_c[0] = i_in.u_x; assign u_c[1] = i_in.u_y; assign u_c[2] = i_in.u_z;
    assign v_c[0] = i_in.v_x; assign v_c[1] = i_in.v_y; assign v_c[2] = i_in.v_z;

    // component lanes
    for (genvar k = 0; k < 3; k++) begin : g_lane
        v3a_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_op     (i_in.op),
            .i_u_self (u_c[k]),
            .i_v_self (v_c[k]),
            .i_u_k1   (u_c[(k+1)%3]),
            .i_v_k2   (v_c[(k+2)%3]),
            .i_u_k2   (u_c[(k+2)%3]),
            .i_v_k1   (v_c[(k+1)%3]),
            .o_lane   (lane[k])
        );
    end

    // merge: dot product sum and sum of squares
    assign dot_sum = 66'(lane[0].prod) + 66'(lane[1].prod) + 66'(lane[2].prod);
    assign dot_s   = v3a_pkg::sat32(v3a_pkg::round_q16(dot_sum));
    assign sq_sum  = 64'(lane[0].prod) + 64'(lane[1].prod) + 64'(lane[2].prod);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1       <= i_in.op;
            r_op2       <= r_op1;
            r_s2_scalar <= (r_op1 == v3a_pkg::OP_DOT) ? dot_s.val : 32'd0;
            r_s2_ovf    <= (r_op1 == v3a_pkg::OP_DOT) && dot_s.ovf;
            r_s2_sq     <= sq_sum;
        end
    end

    // item data riding beside the square root and dividers
    always_comb begin
        n_side0.op     = r_op2;
        n_side0.scalar = r_s2_scalar;
        n_side0.ovf    = r_s2_ovf || lane[0].ovf || lane[1].ovf || lane[2].ovf;
        n_side0.zlen   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_side0.res[k] = lane[k].res;
            n_side0.neg[k] = lane[k].neg;
            n_side0.mag[k] = lane[k].mag;
        end
    end

    // zero-length flag picked up where the length comes out of the square root
    always_comb begin
        n_side_sq      = r_side[v3a_pkg::SQRT_N-1];
        n_side_sq.zlen = (r_side[v3a_pkg::SQRT_N-1].op == v3a_pkg::OP_NORM) &&
                         (len == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= (k == v3a_pkg::SQRT_N) ? n_side_sq : r_side[k-1];
            end
        end
    end

    v3a_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s   (r_s2_sq),
        .o_len (len)
    );

    for (genvar k = 0; k < 3; k++) begin : g_div
        v3a_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (r_side[v3a_pkg::SQRT_N-1].mag[k]),
            .i_len (len),
            .o_q   (q[k])
        );
    end

    // final selection
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [31:0] qv;
            qv = 32'(q[k]);
            if (r_side[SIDE_N-1].op == v3a_pkg::OP_NORM) begin
                if (r_side[SIDE_N-1].zlen) begin
                    n_r[k] = '0;
                end else begin
                    n_r[k] = r_side[SIDE_N-1].neg[k] ? 32'(-qv) : qv;
                end
            end else begin
                n_r[k] = r_side[SIDE_N-1].res[k];
            end
        end
        n_sc = r_side[SIDE_N-1].scalar;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx   <= n_r[0];
            r_ry   <= n_r[1];
            r_rz   <= n_r[2];
            r_sc   <= n_sc;
            r_ovf  <= r_side[SIDE_N-1].ovf;
            r_zlen <= r_side[SIDE_N-1].zlen;
        end
    end

    assign o_out.valid       = r_vld[VLD_N-1];
    assign o_out.r_x         = r_rx;
    assign o_out.r_y         = r_ry;
    assign o_out.r_z         = r_rz;
    assign o_out.scalar      = r_sc;
    assign o_out.overflow    = r_ovf;
    assign o_out.zero_length = r_zlen;

    // checks
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_zlen_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_length) |->
        (o_out.r_x == 0 && o_out.r_y == 0 && o_out.r_z == 0 && o_out.scalar == 0))
        else $error("zero-length result is not all zeros");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.zero_length && o_out.overflow))
        else $error("overflow and zero_length both set");

    a_scalar_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.scalar != 0) |->
        (o_out.r_x == 0 && o_out.r_y == 0 && o_out.r_z == 0))
        else $error("dot result with nonzero vector");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_vld)))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
